// ===== rtl/vmx_pkg.sv =====
`default_nettype none
package vmx_pkg;

   localparam logic [4:0] OP_MOVRI = 5'd0;
   localparam logic [4:0] OP_MOVRM = 5'd1;
   localparam logic [4:0] OP_MOVRR = 5'd2;
   localparam logic [4:0] OP_MOVMI = 5'd3;
   localparam logic [4:0] OP_MOVMM = 5'd4;
   localparam logic [4:0] OP_MOVMR = 5'd5;
   localparam logic [4:0] OP_ADDR  = 5'd6;
   localparam logic [4:0] OP_ADDI  = 5'd7;
   localparam logic [4:0] OP_ADDM  = 5'd8;
   localparam logic [4:0] OP_SUBR  = 5'd9;
   localparam logic [4:0] OP_SUBI  = 5'd10;
   localparam logic [4:0] OP_SUBM  = 5'd11;
   localparam logic [4:0] OP_MULR  = 5'd12;
   localparam logic [4:0] OP_MULI  = 5'd13;
   localparam logic [4:0] OP_MULM  = 5'd14;
   localparam logic [4:0] OP_DIVR  = 5'd15;
   localparam logic [4:0] OP_DIVI  = 5'd16;
   localparam logic [4:0] OP_DIVM  = 5'd17;
   localparam logic [4:0] OP_IFRR  = 5'd18;
   localparam logic [4:0] OP_RET   = 5'd19;
   localparam logic [4:0] OP_HALT  = 5'd20;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_OP   = 3'd1;
   localparam logic [2:0] ST_BAD_CMP  = 3'd2;
   localparam logic [2:0] ST_DIV_ZERO = 3'd3;
   localparam logic [2:0] ST_BAD_REG  = 3'd4;

   localparam int REG_ADDR_W = 6;
   localparam logic [7:0] CMP_KINDS = 8'd6;

   typedef enum logic [2:0] {
      CLS_MOVE, CLS_STORE, CLS_ARITH, CLS_BRANCH, CLS_RET, CLS_NONE
   } cls_type;

   typedef enum logic [1:0] {SRC_IMM, SRC_REG, SRC_CELL} src_type;

   typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_type;

   typedef enum logic [2:0] {CMP_EQ, CMP_NE, CMP_GT, CMP_LT, CMP_GE, CMP_LE} cmp_type;

   typedef enum logic [2:0] {BK_IDLE, BK_READ, BK_MUL, BK_DIV, BK_SIGN} bk_state_type;

   typedef struct packed {
      cls_type                cls;
      src_type                src;
      alu_type                alu;
      cmp_type                cmp;
      logic [2:0]             status;
      logic [3:0]             rd;
      logic [REG_ADDR_W-1:0]  b_addr;
      logic                   cell_ok;
      logic [7:0]             cell_index;
      logic [63:0]            imm;
   } instr_type;

endpackage
`default_nettype wire

// ===== rtl/vmx_front.sv =====
`default_nettype none
module vmx_front #(
   parameter int REG_COUNT  = 16,
   parameter int CELL_COUNT = 256
) (
   input  wire logic                     start,
   input  wire logic                     full,
   input  wire logic [4:0]               req_op,
   input  wire logic [3:0]               req_dest_reg,
   input  wire logic [3:0]               req_src_reg,
   input  wire logic [7:0]               req_cell_index,
   input  wire logic signed [63:0]       req_immediate,
   input  wire logic signed [7:0]        req_cond_code,
   output logic                          busy,
   output logic                          push,
   output vmx_pkg::instr_type            instr
);

   logic rd_ok;
   logic rs_ok;
   logic imm_ok;

   always_comb begin
      rd_ok  = 32'(req_dest_reg) < REG_COUNT;
      rs_ok  = 32'(req_src_reg) < REG_COUNT;
      imm_ok = (req_immediate[63:vmx_pkg::REG_ADDR_W] == '0) &&
               (32'(req_immediate[vmx_pkg::REG_ADDR_W-1:0]) < REG_COUNT);

      instr.cls        = vmx_pkg::CLS_NONE;
      instr.src        = vmx_pkg::SRC_IMM;
      instr.alu        = vmx_pkg::ALU_ADD;
      instr.cmp        = vmx_pkg::CMP_EQ;
      instr.status     = vmx_pkg::ST_OK;
      instr.rd         = req_dest_reg;
      instr.b_addr     = vmx_pkg::REG_ADDR_W'(req_src_reg);
      instr.cell_ok    = 32'(req_cell_index) < CELL_COUNT;
      instr.cell_index = req_cell_index;
      instr.imm        = req_immediate;

      case (req_op)
         vmx_pkg::OP_MOVRI, vmx_pkg::OP_MOVRM: begin
            instr.cls = vmx_pkg::CLS_MOVE;
            if (!rd_ok) instr.status = vmx_pkg::ST_BAD_REG;
         end
         vmx_pkg::OP_MOVRR: begin
            instr.cls = vmx_pkg::CLS_MOVE;
            instr.src = vmx_pkg::SRC_REG;
            if (!rd_ok || !rs_ok) instr.status = vmx_pkg::ST_BAD_REG;
         end
         vmx_pkg::OP_MOVMI: begin
            instr.cls = vmx_pkg::CLS_STORE;
         end
         vmx_pkg::OP_MOVMM: begin
            instr.cls    = vmx_pkg::CLS_STORE;
            instr.src    = vmx_pkg::SRC_REG;
            instr.b_addr = req_immediate[vmx_pkg::REG_ADDR_W-1:0];
            if (!imm_ok) instr.status = vmx_pkg::ST_BAD_REG;
         end
         vmx_pkg::OP_MOVMR: begin
            instr.cls = vmx_pkg::CLS_STORE;
            instr.src = vmx_pkg::SRC_REG;
            if (!rs_ok) instr.status = vmx_pkg::ST_BAD_REG;
         end
         vmx_pkg::OP_ADDR, vmx_pkg::OP_ADDI, vmx_pkg::OP_ADDM,
         vmx_pkg::OP_SUBR, vmx_pkg::OP_SUBI, vmx_pkg::OP_SUBM,
         vmx_pkg::OP_MULR, vmx_pkg::OP_MULI, vmx_pkg::OP_MULM,
         vmx_pkg::OP_DIVR, vmx_pkg::OP_DIVI, vmx_pkg::OP_DIVM: begin
            instr.cls = vmx_pkg::CLS_ARITH;
            if (req_op inside {[vmx_pkg::OP_ADDR:vmx_pkg::OP_ADDM]}) begin
               instr.alu = vmx_pkg::ALU_ADD;
            end else if (req_op inside {[vmx_pkg::OP_SUBR:vmx_pkg::OP_SUBM]}) begin
               instr.alu = vmx_pkg::ALU_SUB;
            end else if (req_op inside {[vmx_pkg::OP_MULR:vmx_pkg::OP_MULM]}) begin
               instr.alu = vmx_pkg::ALU_MUL;
            end else begin
               instr.alu = vmx_pkg::ALU_DIV;
            end
            if (req_op inside {vmx_pkg::OP_ADDR, vmx_pkg::OP_SUBR,
                               vmx_pkg::OP_MULR, vmx_pkg::OP_DIVR}) begin
               instr.src = vmx_pkg::SRC_REG;
            end else if (req_op inside {vmx_pkg::OP_ADDM, vmx_pkg::OP_SUBM,
                                        vmx_pkg::OP_MULM, vmx_pkg::OP_DIVM}) begin
               instr.src = vmx_pkg::SRC_CELL;
            end else begin
               instr.src = vmx_pkg::SRC_IMM;
            end
            if (!rd_ok || (instr.src == vmx_pkg::SRC_REG && !rs_ok)) begin
               instr.status = vmx_pkg::ST_BAD_REG;
            end
         end
         vmx_pkg::OP_IFRR: begin
            instr.cls = vmx_pkg::CLS_BRANCH;
            instr.cmp = vmx_pkg::cmp_type'(req_cond_code[2:0]);
            if (!rd_ok || !rs_ok) begin
               instr.status = vmx_pkg::ST_BAD_REG;
            end else if ($unsigned(req_cond_code) >= vmx_pkg::CMP_KINDS) begin
               instr.status = vmx_pkg::ST_BAD_CMP;
            end
         end
         vmx_pkg::OP_RET: begin
            instr.cls = vmx_pkg::CLS_RET;
         end
         vmx_pkg::OP_HALT: begin
            instr.cls = vmx_pkg::CLS_NONE;
         end
         default: begin
            instr.status = vmx_pkg::ST_BAD_OP;
         end
      endcase

      busy = full;
      push = start && !full;
   end

endmodule
`default_nettype wire

// ===== rtl/vmx_queue.sv =====
`default_nettype none
module vmx_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire vmx_pkg::instr_type  push_data,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output vmx_pkg::instr_type       head
);

   localparam int QDepth = 2;
   localparam int PtrW   = $clog2(QDepth);

   vmx_pkg::instr_type slot_ff [QDepth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]      count_ff, count_in;

   always_comb begin
      full      = count_ff == (PtrW+1)'(QDepth);
      empty     = count_ff == '0;
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ===== rtl/vmx_back.sv =====
`default_nettype none
module vmx_back #(
   parameter int REG_COUNT  = 16,
   parameter int CELL_COUNT = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                empty,
   input  wire vmx_pkg::instr_type  head,
   output logic                     pop,
   output logic                     rsp_valid,
   output logic signed [63:0]       rsp_write_value,
   output logic                     rsp_wrote_register,
   output logic                     rsp_wrote_cell,
   output logic                     rsp_branch_taken,
   output logic signed [63:0]       rsp_branch_target,
   output logic                     rsp_stop,
   output logic [2:0]               rsp_status
);

   localparam int RegIdxW   = $clog2(REG_COUNT);
   localparam int CellDepth = (CELL_COUNT < 256) ? CELL_COUNT : 256;
   localparam int CellIdxW  = $clog2(CellDepth);

   vmx_pkg::bk_state_type state_ff, state_in;

   logic [63:0]        regs [REG_COUNT];
   logic [REG_COUNT-1:0] reg_set_ff;
   logic [63:0]        cells [CellDepth];
   logic [CellDepth-1:0] cell_valid_ff;

   vmx_pkg::instr_type cur_ff;
   logic [63:0]        rda_ff, rdb_ff, cell_data_ff;
   logic               cell_hit_ff;
   logic [63:0]        opa_ff, opa_in, opb_ff, opb_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        quot_ff, quot_in;
   logic [63:0]        rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;

   logic               rsp_valid_ff;
   logic [63:0]        rsp_value_ff, rsp_target_ff;
   logic               rsp_wreg_ff, rsp_wcell_ff, rsp_taken_ff, rsp_stop_ff;
   logic [2:0]         rsp_status_ff;

   logic               fin;
   logic [63:0]        fin_value, fin_target;
   logic               fin_wreg, fin_wcell, fin_taken, fin_stop;
   logic [2:0]         fin_status;

   logic [RegIdxW-1:0] a_idx, b_idx, wr_idx;
   logic [CellIdxW-1:0] c_idx, cw_idx;
   logic [63:0]        opnd;
   logic               have;
   logic               lt, eq, cond;
   logic [31:0]        mul_x, mul_y;
   logic [63:0]        prod;
   logic [64:0]        rem_w, diff;
   logic [63:0]        mag_a, mag_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vmx_pkg::BK_IDLE: if (!empty) state_in = vmx_pkg::BK_READ;
         vmx_pkg::BK_READ: begin
            state_in = vmx_pkg::BK_IDLE;
            if (cur_ff.status == vmx_pkg::ST_OK && cur_ff.cls == vmx_pkg::CLS_ARITH && have) begin
               if (cur_ff.alu == vmx_pkg::ALU_MUL) begin
                  state_in = vmx_pkg::BK_MUL;
               end else if (cur_ff.alu == vmx_pkg::ALU_DIV && opnd != '0) begin
                  state_in = vmx_pkg::BK_DIV;
               end
            end
         end
         vmx_pkg::BK_MUL: if (cnt_ff == 6'd2) state_in = vmx_pkg::BK_IDLE;
         vmx_pkg::BK_DIV: if (cnt_ff == 6'd63) state_in = vmx_pkg::BK_SIGN;
         vmx_pkg::BK_SIGN: state_in = vmx_pkg::BK_IDLE;
         default: state_in = vmx_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop    = (state_ff == vmx_pkg::BK_IDLE) && !empty;
      a_idx  = RegIdxW'(head.rd);
      b_idx  = RegIdxW'(head.b_addr);
      c_idx  = CellIdxW'(head.cell_index);
      wr_idx = RegIdxW'(cur_ff.rd);
      cw_idx = CellIdxW'(cur_ff.cell_index);

      case (cur_ff.src)
         vmx_pkg::SRC_REG:  opnd = rdb_ff;
         vmx_pkg::SRC_CELL: opnd = cell_data_ff;
         default:           opnd = cur_ff.imm;
      endcase
      have = (cur_ff.src != vmx_pkg::SRC_CELL) || cell_hit_ff;

      eq = rda_ff == rdb_ff;
      lt = $signed(rda_ff) < $signed(rdb_ff);
      case (cur_ff.cmp)
         vmx_pkg::CMP_EQ: cond = eq;
         vmx_pkg::CMP_NE: cond = !eq;
         vmx_pkg::CMP_GT: cond = !lt && !eq;
         vmx_pkg::CMP_LT: cond = lt;
         vmx_pkg::CMP_GE: cond = !lt;
         default:         cond = lt || eq;
      endcase

      mul_x = (cnt_ff == 6'd2) ? opa_ff[63:32] : opa_ff[31:0];
      mul_y = (cnt_ff == 6'd1) ? opb_ff[63:32] : opb_ff[31:0];
      prod  = 64'(mul_x) * 64'(mul_y);

      rem_w = {rem_ff, quot_ff[63]};
      diff  = rem_w - {1'b0, opb_ff};
      mag_a = rda_ff[63] ? (~rda_ff + 64'd1) : rda_ff;
      mag_b = opnd[63] ? (~opnd + 64'd1) : opnd;

      opa_in  = opa_ff;
      opb_in  = opb_ff;
      acc_in  = acc_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;

      fin        = 1'b0;
      fin_value  = '0;
      fin_target = '0;
      fin_wreg   = 1'b0;
      fin_wcell  = 1'b0;
      fin_taken  = 1'b0;
      fin_stop   = 1'b0;
      fin_status = vmx_pkg::ST_OK;

      case (state_ff)
         vmx_pkg::BK_READ: begin
            fin        = 1'b1;
            fin_status = cur_ff.status;
            opa_in     = rda_ff;
            opb_in     = opnd;
            cnt_in     = '0;
            acc_in     = '0;
            if (cur_ff.status == vmx_pkg::ST_OK) begin
               case (cur_ff.cls)
                  vmx_pkg::CLS_MOVE: begin
                     fin_value = opnd;
                     fin_wreg  = 1'b1;
                  end
                  vmx_pkg::CLS_STORE: begin
                     if (cur_ff.cell_ok) begin
                        fin_value = opnd;
                        fin_wcell = 1'b1;
                     end
                  end
                  vmx_pkg::CLS_ARITH: begin
                     if (have) begin
                        case (cur_ff.alu)
                           vmx_pkg::ALU_ADD: begin
                              fin_value = rda_ff + opnd;
                              fin_wreg  = 1'b1;
                           end
                           vmx_pkg::ALU_SUB: begin
                              fin_value = rda_ff - opnd;
                              fin_wreg  = 1'b1;
                           end
                           vmx_pkg::ALU_MUL: begin
                              fin = 1'b0;
                           end
                           default: begin
                              if (opnd == '0) begin
                                 fin_status = vmx_pkg::ST_DIV_ZERO;
                              end else begin
                                 fin     = 1'b0;
                                 opa_in  = mag_a;
                                 opb_in  = mag_b;
                                 quot_in = mag_a;
                                 rem_in  = '0;
                                 neg_in  = rda_ff[63] ^ opnd[63];
                              end
                           end
                        endcase
                     end
                  end
                  vmx_pkg::CLS_BRANCH: begin
                     if (cond) begin
                        fin_taken  = 1'b1;
                        fin_target = cur_ff.imm;
                     end
                  end
                  vmx_pkg::CLS_RET: fin_stop = 1'b1;
                  default: ;
               endcase
            end
         end
         vmx_pkg::BK_MUL: begin
            acc_in = (cnt_ff == '0) ? prod : acc_ff + {prod[31:0], 32'd0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               fin       = 1'b1;
               fin_value = acc_in;
               fin_wreg  = 1'b1;
            end
         end
         vmx_pkg::BK_DIV: begin
            if (!diff[64]) begin
               rem_in  = diff[63:0];
               quot_in = {quot_ff[62:0], 1'b1};
            end else begin
               rem_in  = rem_w[63:0];
               quot_in = {quot_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
         end
         vmx_pkg::BK_SIGN: begin
            fin       = 1'b1;
            fin_value = neg_ff ? (~quot_ff + 64'd1) : quot_ff;
            fin_wreg  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vmx_pkg::BK_IDLE;
         reg_set_ff    <= '0;
         cell_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin;
         if (fin && fin_wreg) reg_set_ff[wr_idx] <= 1'b1;
         if (fin && fin_wcell) cell_valid_ff[cw_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fin && fin_wreg) regs[wr_idx] <= fin_value;
      if (fin && fin_wcell) cells[cw_idx] <= fin_value;
      if (pop) begin
         cur_ff       <= head;
         rda_ff       <= reg_set_ff[a_idx] ? regs[a_idx] : '0;
         rdb_ff       <= reg_set_ff[b_idx] ? regs[b_idx] : '0;
         cell_data_ff <= cells[c_idx];
         cell_hit_ff  <= head.cell_ok && cell_valid_ff[c_idx];
      end
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      rsp_value_ff  <= fin_value;
      rsp_target_ff <= fin_target;
      rsp_wreg_ff   <= fin_wreg;
      rsp_wcell_ff  <= fin_wcell;
      rsp_taken_ff  <= fin_taken;
      rsp_stop_ff   <= fin_stop;
      rsp_status_ff <= fin_status;
   end

   always_comb begin
      rsp_valid          = rsp_valid_ff;
      rsp_write_value    = rsp_value_ff;
      rsp_wrote_register = rsp_wreg_ff;
      rsp_wrote_cell     = rsp_wcell_ff;
      rsp_branch_taken   = rsp_taken_ff;
      rsp_branch_target  = rsp_target_ff;
      rsp_stop           = rsp_stop_ff;
      rsp_status         = rsp_status_ff;
   end

endmodule
`default_nettype wire

// ===== rtl/vm_register_execute_unit.sv =====
// A start transfer enters the queue, is popped into the back end's registers while it is idle,
// and runs in its read state, which registers rsp_valid for moves, stores, add, sub, compare;
// multiply forms three 32x32 partial products, divide one quotient bit a cycle. The back end
// takes a new instruction only when done with the last; a 2-entry queue lets start transfers
// continue while it works. Reset: synchronous; registers and cell valid marks read as cleared,
// no clearing pass. The receiver cannot stall; each result shows for one cycle with rsp_valid.
`default_nettype none
module vm_register_execute_unit #(
   parameter int REG_COUNT  = 16,
   parameter int CELL_COUNT = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [4:0]          req_op,
   input  wire logic [3:0]          req_dest_reg,
   input  wire logic [3:0]          req_src_reg,
   input  wire logic [7:0]          req_cell_index,
   input  wire logic signed [63:0]  req_immediate,
   input  wire logic signed [7:0]   req_cond_code,
   output logic                     rsp_valid,
   output logic signed [63:0]       rsp_write_value,
   output logic                     rsp_wrote_register,
   output logic                     rsp_wrote_cell,
   output logic                     rsp_branch_taken,
   output logic signed [63:0]       rsp_branch_target,
   output logic                     rsp_stop,
   output logic [2:0]               rsp_status
);

   logic               full;
   logic               empty;
   logic               push;
   logic               pop;
   vmx_pkg::instr_type instr;
   vmx_pkg::instr_type head;

   vmx_front #(
      .REG_COUNT  (REG_COUNT),
      .CELL_COUNT (CELL_COUNT)
   ) u_front (
      .start          (start),
      .full           (full),
      .req_op         (req_op),
      .req_dest_reg   (req_dest_reg),
      .req_src_reg    (req_src_reg),
      .req_cell_index (req_cell_index),
      .req_immediate  (req_immediate),
      .req_cond_code  (req_cond_code),
      .busy           (busy),
      .push           (push),
      .instr          (instr)
   );

   vmx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (instr),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   vmx_back #(
      .REG_COUNT  (REG_COUNT),
      .CELL_COUNT (CELL_COUNT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_write_value    (rsp_write_value),
      .rsp_wrote_register (rsp_wrote_register),
      .rsp_wrote_cell     (rsp_wrote_cell),
      .rsp_branch_taken   (rsp_branch_taken),
      .rsp_branch_target  (rsp_branch_target),
      .rsp_stop           (rsp_stop),
      .rsp_status         (rsp_status)
   );

endmodule
`default_nettype wire

// ===== dv/vm_register_execute_unit_checker.sv =====
`default_nettype none
module vm_register_execute_unit_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [4:0]         req_op,
   input  wire logic [3:0]         req_dest_reg,
   input  wire logic [3:0]         req_src_reg,
   input  wire logic [7:0]         req_cell_index,
   input  wire logic signed [63:0] req_immediate,
   input  wire logic signed [7:0]  req_cond_code,
   input  wire logic               rsp_valid,
   input  wire logic signed [63:0] rsp_write_value,
   input  wire logic               rsp_wrote_register,
   input  wire logic               rsp_wrote_cell,
   input  wire logic               rsp_branch_taken,
   input  wire logic signed [63:0] rsp_branch_target,
   input  wire logic               rsp_stop,
   input  wire logic [2:0]         rsp_status,
   output int                      errors,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NREGS  = 16;
   localparam int NCELLS = 256;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

   typedef struct {
      logic [63:0] write_value;
      logic        wrote_register;
      logic        wrote_cell;
      logic        branch_taken;
      logic [63:0] branch_target;
      logic        stop;
      logic [2:0]  status;
   } outcome_type;

   logic [63:0] regs [NREGS];
   logic [63:0] cells [NCELLS];
   logic        cell_live [NCELLS];
   outcome_type outcomes_due [$];

   function automatic logic [63:0] quotient(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic logic branch_holds(logic [7:0] cc, logic [63:0] l, logic [63:0] r);
      logic lt, gt;
      lt = (l ^ SIGN_BIT) < (r ^ SIGN_BIT);
      gt = (r ^ SIGN_BIT) < (l ^ SIGN_BIT);
      case (vmx_pkg::cmp_type'(cc[2:0]))
         vmx_pkg::CMP_EQ: return l == r;
         vmx_pkg::CMP_NE: return l != r;
         vmx_pkg::CMP_GT: return gt;
         vmx_pkg::CMP_LT: return lt;
         vmx_pkg::CMP_GE: return !lt;
         default: return !gt;
      endcase
   endfunction

   task automatic execute(input logic [4:0] op, input logic [3:0] rd, input logic [3:0] rs,
                          input logic [7:0] ci, input logic [63:0] imm, input logic [7:0] cc);
      outcome_type o;
      logic [63:0] v, operand, a, r;
      logic have;
      int kind, form;
      o = '{default: '0};
      o.status = vmx_pkg::ST_OK;
      if (op == vmx_pkg::OP_MOVRI || op == vmx_pkg::OP_MOVRM) begin
         regs[rd] = imm;
         o.write_value = imm;
         o.wrote_register = 1'b1;
      end else if (op == vmx_pkg::OP_MOVRR) begin
         regs[rd] = regs[rs];
         o.write_value = regs[rs];
         o.wrote_register = 1'b1;
      end else if (op >= vmx_pkg::OP_MOVMI && op <= vmx_pkg::OP_MOVMR) begin
         v = imm;
         if (op == vmx_pkg::OP_MOVMM && imm >= 64'(NREGS)) begin
            o.status = vmx_pkg::ST_BAD_REG;
         end else begin
            if (op == vmx_pkg::OP_MOVMM) v = regs[imm[3:0]];
            if (op == vmx_pkg::OP_MOVMR) v = regs[rs];
            cells[ci] = v;
            cell_live[ci] = 1'b1;
            o.write_value = v;
            o.wrote_cell = 1'b1;
         end
      end else if (op >= vmx_pkg::OP_ADDR && op <= vmx_pkg::OP_DIVM) begin
         kind = (int'(op) - 6) / 3;
         form = (int'(op) - 6) % 3;
         have = 1'b1;
         operand = '0;
         if (form == 0) operand = regs[rs];
         else if (form == 1) operand = imm;
         else if (cell_live[ci]) operand = cells[ci];
         else have = 1'b0;
         if (have) begin
            a = regs[rd];
            r = '0;
            case (vmx_pkg::alu_type'(kind))
               vmx_pkg::ALU_ADD: r = a + operand;
               vmx_pkg::ALU_SUB: r = a - operand;
               vmx_pkg::ALU_MUL: r = a * operand;
               default: begin
                  if (operand == '0) begin
                     o.status = vmx_pkg::ST_DIV_ZERO;
                     have = 1'b0;
                  end else begin
                     r = quotient(a, operand);
                  end
               end
            endcase
            if (have) begin
               regs[rd] = r;
               o.write_value = r;
               o.wrote_register = 1'b1;
            end
         end
      end else if (op == vmx_pkg::OP_IFRR) begin
         if (cc >= vmx_pkg::CMP_KINDS) o.status = vmx_pkg::ST_BAD_CMP;
         else if (branch_holds(cc, regs[rd], regs[rs])) begin
            o.branch_taken = 1'b1;
            o.branch_target = imm;
         end
      end else if (op == vmx_pkg::OP_RET) begin
         o.stop = 1'b1;
      end else if (op != vmx_pkg::OP_HALT) begin
         o.status = vmx_pkg::ST_BAD_OP;
      end
      outcomes_due.insert(outcomes_due.size(), o);
   endtask

   task automatic report(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
      for (int i = 0; i < NREGS; i++) regs[i] = '0;
      for (int i = 0; i < NCELLS; i++) begin
         cells[i] = '0;
         cell_live[i] = 1'b0;
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: unexpected result, actual status %0d value %h",
                        $time, rsp_status, rsp_write_value);
               errors++;
            end else begin
               want = outcomes_due.pop_front();
               report("write_value", want.write_value, rsp_write_value);
               report("wrote_register", 64'(want.wrote_register), 64'(rsp_wrote_register));
               report("wrote_cell", 64'(want.wrote_cell), 64'(rsp_wrote_cell));
               report("branch_taken", 64'(want.branch_taken), 64'(rsp_branch_taken));
               report("branch_target", want.branch_target, rsp_branch_target);
               report("stop", 64'(want.stop), 64'(rsp_stop));
               report("status", 64'(want.status), 64'(rsp_status));
            end
         end
         if (start && !busy)
            execute(req_op, req_dest_reg, req_src_reg, req_cell_index, req_immediate,
                    req_cond_code);
      end
      pending = outcomes_due.size();
   end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [4:0] req_op = '0;
   logic [3:0] req_dest_reg = '0;
   logic [3:0] req_src_reg = '0;
   logic [7:0] req_cell_index = '0;
   logic signed [63:0] req_immediate = '0;
   logic signed [7:0] req_cond_code = '0;
   logic rsp_valid;
   logic signed [63:0] rsp_write_value;
   logic rsp_wrote_register;
   logic rsp_wrote_cell;
   logic rsp_branch_taken;
   logic signed [63:0] rsp_branch_target;
   logic rsp_stop;
   logic [2:0] rsp_status;
   int errors;
   int pending;
   int idle_pct = 0;
   int stale_cycles = 0;
   logic transfer_due = 1'b0;
   int idle_pct_list [4] = '{0, 48, 7, 0};

   always #2 clock = ~clock;

   vm_register_execute_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_dest_reg(req_dest_reg), .req_src_reg(req_src_reg),
      .req_cell_index(req_cell_index), .req_immediate(req_immediate),
      .req_cond_code(req_cond_code), .rsp_valid(rsp_valid),
      .rsp_write_value(rsp_write_value), .rsp_wrote_register(rsp_wrote_register),
      .rsp_wrote_cell(rsp_wrote_cell), .rsp_branch_taken(rsp_branch_taken),
      .rsp_branch_target(rsp_branch_target), .rsp_stop(rsp_stop), .rsp_status(rsp_status)
   );

   vm_register_execute_unit_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_dest_reg(req_dest_reg), .req_src_reg(req_src_reg),
      .req_cell_index(req_cell_index), .req_immediate(req_immediate),
      .req_cond_code(req_cond_code), .rsp_valid(rsp_valid),
      .rsp_write_value(rsp_write_value), .rsp_wrote_register(rsp_wrote_register),
      .rsp_wrote_cell(rsp_wrote_cell), .rsp_branch_taken(rsp_branch_taken),
      .rsp_branch_target(rsp_branch_target), .rsp_stop(rsp_stop), .rsp_status(rsp_status),
      .errors(errors), .pending(pending)
   );

   // sample the handshake mid-cycle, when it is stable
   always @(negedge clock) transfer_due = start && !busy && !reset;

   always @(posedge clock) begin
      if (reset || transfer_due || rsp_valid) stale_cycles <= 0;
      else stale_cycles <= stale_cycles + 1;
      if (stale_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic issue(input logic [4:0] op, input logic [3:0] rd, input logic [3:0] rs,
                        input logic [7:0] ci, input logic [63:0] imm, input logic [7:0] cc);
      if (idle_pct > 0) begin
         while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_op <= op;
      req_dest_reg <= rd;
      req_src_reg <= rs;
      req_cell_index <= ci;
      req_immediate <= imm;
      req_cond_code <= cc;
      do @(posedge clock); while (!transfer_due);
   endtask

   function automatic logic [63:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 35) return 64'(signed'($urandom_range(0, 16)) - 8);
      if (sel < 55) begin
         case ($urandom_range(0, 3))
            0: return MAX_VAL;
            1: return MIN_VAL;
            2: return '0;
            default: return '1;
         endcase
      end
      return {$urandom, $urandom};
   endfunction

   task automatic random_item();
      logic [4:0] op;
      logic [7:0] ci, cc;
      logic [63:0] imm;
      if ($urandom_range(0, 99) < 5) op = 5'($urandom_range(21, 31));
      else op = 5'($urandom_range(0, 20));
      ci = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      cc = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 5)) : 8'($urandom);
      if (op == vmx_pkg::OP_MOVMM && $urandom_range(0, 99) < 80)
         imm = 64'($urandom_range(0, 15));
      else imm = pick_value();
      issue(op, 4'($urandom), 4'($urandom), ci, imm, cc);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(vmx_pkg::OP_MOVRI, 4'd0, 4'd0, 8'd0, MAX_VAL, 8'd0);
      issue(vmx_pkg::OP_MOVRI, 4'd1, 4'd0, 8'd0, MIN_VAL, 8'd0);
      issue(vmx_pkg::OP_MOVRM, 4'd2, 4'd0, 8'd0, '1, 8'd0);
      issue(vmx_pkg::OP_MOVRR, 4'd15, 4'd1, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_MOVMI, 4'd0, 4'd0, 8'd0, 64'd7, 8'd0);
      issue(vmx_pkg::OP_MOVMM, 4'd0, 4'd0, 8'd1, 64'd2, 8'd0);
      issue(vmx_pkg::OP_MOVMM, 4'd0, 4'd0, 8'd2, 64'd16, 8'd0);
      issue(vmx_pkg::OP_MOVMM, 4'd0, 4'd0, 8'd2, MIN_VAL, 8'd0);
      issue(vmx_pkg::OP_MOVMR, 4'd0, 4'd0, 8'd255, '0, 8'd0);
      issue(vmx_pkg::OP_ADDR, 4'd0, 4'd2, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_ADDI, 4'd0, 4'd0, 8'd0, 64'd1, 8'd0);
      issue(vmx_pkg::OP_ADDM, 4'd2, 4'd0, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_ADDM, 4'd2, 4'd0, 8'd77, '0, 8'd0);
      issue(vmx_pkg::OP_SUBR, 4'd3, 4'd1, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_SUBI, 4'd4, 4'd0, 8'd0, MIN_VAL, 8'd0);
      issue(vmx_pkg::OP_SUBM, 4'd5, 4'd0, 8'd1, '0, 8'd0);
      issue(vmx_pkg::OP_MULR, 4'd2, 4'd0, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_MULI, 4'd0, 4'd0, 8'd0, 64'd3, 8'd0);
      issue(vmx_pkg::OP_MULM, 4'd0, 4'd0, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_DIVR, 4'd0, 4'd6, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_DIVI, 4'd1, 4'd0, 8'd0, '1, 8'd0);
      issue(vmx_pkg::OP_DIVI, 4'd0, 4'd0, 8'd0, 64'hffff_ffff_ffff_fffd, 8'd0);
      issue(vmx_pkg::OP_DIVM, 4'd15, 4'd0, 8'd0, '0, 8'd0);
      for (int k = 0; k < 6; k++)
         issue(vmx_pkg::OP_IFRR, 4'd0, 4'd1, 8'd0, 64'(k + 100), 8'(k));
      issue(vmx_pkg::OP_IFRR, 4'd0, 4'd0, 8'd0, 64'd5, 8'd6);
      issue(vmx_pkg::OP_IFRR, 4'd0, 4'd0, 8'd0, 64'd5, 8'hff);
      issue(vmx_pkg::OP_RET, 4'd0, 4'd0, 8'd0, '0, 8'd0);
      issue(vmx_pkg::OP_HALT, 4'd0, 4'd0, 8'd0, '0, 8'd0);
      issue(5'd31, 4'd0, 4'd0, 8'd0, '0, 8'd0);

      foreach (idle_pct_list[p]) begin
         idle_pct = idle_pct_list[p];
         repeat (200) random_item();
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
